// File: hdl/ctse_pkg.sv
// Shared types, command and cursor codes, and calendar helpers for the
// time-set editor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctse_pkg;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_NEXT   = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_CHANGE = 2'd3
  } kind_t;

  // Edit cursor codes
  localparam logic [2:0] CUR_NONE   = 3'd0;
  localparam logic [2:0] CUR_HOUR   = 3'd1;
  localparam logic [2:0] CUR_MINUTE = 3'd2;
  localparam logic [2:0] CUR_SECOND = 3'd3;
  localparam logic [2:0] CUR_DATE   = 3'd4;
  localparam logic [2:0] CUR_MONTH  = 3'd5;
  localparam logic [2:0] CUR_YEAR   = 3'd6;

  // Field bounds
  localparam logic [6:0] HOUR_TOP   = 7'd23;
  localparam logic [6:0] MINUTE_TOP = 7'd59;
  localparam logic [6:0] MONTH_TOP  = 7'd12;
  localparam logic [6:0] YEAR_TOP   = 7'd99;
  localparam logic [6:0] ZERO_BOT   = 7'd0;
  localparam logic [6:0] ONE_BOT    = 7'd1;

  // Calendar time
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } time_t;

  // One command as held in the input register
  typedef struct packed {
    kind_t             kind;
    logic signed [3:0] step;
    time_t             load;
  } cmd_t;

  // Add a signed step; past the top goes to the bottom, below the bottom to the top
  function automatic logic [6:0] wrap_add(input logic [6:0] v,
                                          input logic signed [3:0] step,
                                          input logic [6:0] bottom,
                                          input logic [6:0] top);
    logic signed [8:0] r;
    r = $signed({2'b00, v}) + 9'(step);
    if (r > $signed({2'b00, top})) begin
      r = $signed({2'b00, bottom});
    end else if (r < $signed({2'b00, bottom})) begin
      r = $signed({2'b00, top});
    end
    return r[6:0];
  endfunction

  // Days in month; leap February when the year is a multiple of four
  function automatic logic [4:0] month_days(input logic [3:0] month,
                                            input logic [6:0] year);
    logic [4:0] d;
    case (month)
      4'd2:    d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // floor(31 * m / 12) for a 4-bit m
  function automatic logic [5:0] month_offset(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd0:    t = 6'd0;
      4'd1:    t = 6'd2;
      4'd2:    t = 6'd5;
      4'd3:    t = 6'd7;
      4'd4:    t = 6'd10;
      4'd5:    t = 6'd12;
      4'd6:    t = 6'd15;
      4'd7:    t = 6'd18;
      4'd8:    t = 6'd20;
      4'd9:    t = 6'd23;
      4'd10:   t = 6'd25;
      4'd11:   t = 6'd28;
      4'd12:   t = 6'd31;
      4'd13:   t = 6'd33;
      4'd14:   t = 6'd36;
      default: t = 6'd38;
    endcase
    return t;
  endfunction

  // Day of week 1..7 from date, month and two-digit year (0 shows as 7)
  function automatic logic [2:0] calc_weekday(input logic [4:0] day,
                                              input logic [3:0] month,
                                              input logic [6:0] year);
    logic       a;
    logic [7:0] y;
    logic [4:0] m5;
    logic [7:0] sum;
    logic [4:0] f1;
    logic [3:0] f2;
    logic [2:0] w;
    a   = (month <= 4'd2);
    y   = 8'd12 + {1'b0, year} - {7'd0, a};
    m5  = {1'b0, month} + (a ? 5'd12 : 5'd0) - 5'd2;
    sum = {3'd0, day} + y + {2'b00, y[7:2]} + {2'b00, month_offset(m5[3:0])};
    // mod 7 by folding octal digits (8 == 1 mod 7)
    f1  = {2'b00, sum[2:0]} + {2'b00, sum[5:3]} + {3'b000, sum[7:6]};
    f2  = {1'b0, f1[2:0]} + {2'b00, f1[4:3]};
    w   = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    return (w == 3'd0) ? 3'd7 : w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ctse_next.sv
// Next-state logic of the time-set editor: applies one command to the
// cursor and calendar time. Depends on ctse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctse_next (
  input  ctse_pkg::cmd_t  cmd,
  input  logic [2:0]      cursor,
  input  ctse_pkg::time_t cur_time,
  output logic [2:0]      cursor_nxt,
  output ctse_pkg::time_t time_nxt,
  output logic            strobe
);
  import ctse_pkg::*;

  time_t      stepped;
  logic [4:0] md_old;
  logic [4:0] md_new;
  logic [6:0] w_hour;
  logic [6:0] w_minute;
  logic [6:0] w_day;
  logic [6:0] w_month;
  logic [6:0] w_year;

  // Wrapped candidates for each steppable field
  assign md_old   = month_days(cur_time.month, cur_time.year);
  assign w_hour   = wrap_add({2'b00, cur_time.hour}, cmd.step, ZERO_BOT, HOUR_TOP);
  assign w_minute = wrap_add({1'b0, cur_time.minute}, cmd.step, ZERO_BOT, MINUTE_TOP);
  assign w_day    = wrap_add({2'b00, cur_time.day}, cmd.step, ONE_BOT, {2'b00, md_old});
  assign w_month  = wrap_add({3'b000, cur_time.month}, cmd.step, ONE_BOT, MONTH_TOP);
  assign w_year   = wrap_add(cur_time.year, cmd.step, ZERO_BOT, YEAR_TOP);

  // Step the field under the cursor; the second field is cleared instead
  always_comb begin
    stepped = cur_time;
    case (cursor)
      CUR_HOUR:   stepped.hour   = w_hour[4:0];
      CUR_MINUTE: stepped.minute = w_minute[5:0];
      CUR_SECOND: stepped.second = 6'd0;
      CUR_DATE:   stepped.day    = w_day[4:0];
      CUR_MONTH:  stepped.month  = w_month[3:0];
      CUR_YEAR:   stepped.year   = w_year;
      default:    stepped = cur_time;
    endcase
  end

  assign md_new = month_days(stepped.month, stepped.year);

  // Command decode; change clamps the date and may recompute the weekday
  always_comb begin
    cursor_nxt = cursor;
    time_nxt   = cur_time;
    strobe     = 1'b0;
    case (cmd.kind)
      KIND_LOAD: begin
        time_nxt = cmd.load;
      end
      KIND_NEXT: begin
        if (cursor >= CUR_HOUR && cursor <= CUR_MONTH) begin
          cursor_nxt = cursor + 3'd1;
        end else begin
          cursor_nxt = CUR_HOUR;
        end
      end
      KIND_STOP: begin
        cursor_nxt = CUR_NONE;
      end
      KIND_CHANGE: begin
        time_nxt = stepped;
        if (stepped.day > md_new) begin
          time_nxt.day = md_new;
        end
        if (cursor >= CUR_DATE && cursor <= CUR_YEAR) begin
          time_nxt.weekday = calc_weekday(time_nxt.day, stepped.month, stepped.year);
        end
        strobe = 1'b1;
      end
      default: begin
        cursor_nxt = cursor;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/clock_time_set_editor.sv
// Calendar time-set editor: a command passes the input register, then the state/result
// register, before its result can transfer; one item per cycle sustained while the
// result channel does not stall, with a single next-state pass between the two registers.
// The state registers are the result register; a stalled result holds them.
// Synchronous active-low reset: cursor none, time 00:00:00, weekday 1,
// date 1, month 1, year 0, both stages empty. Depends on ctse_pkg, ctse_next.
`timescale 1ns / 1ps
`default_nettype none

module clock_time_set_editor (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_step,
  input  logic [5:0] in_load_second,
  input  logic [5:0] in_load_minute,
  input  logic [4:0] in_load_hour,
  input  logic [2:0] in_load_weekday,
  input  logic [4:0] in_load_day,
  input  logic [3:0] in_load_month,
  input  logic [6:0] in_load_year,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_editing,
  output logic [2:0] out_cursor,
  output logic [5:0] out_second,
  output logic [5:0] out_minute,
  output logic [4:0] out_hour,
  output logic [2:0] out_weekday,
  output logic [4:0] out_day,
  output logic [3:0] out_month,
  output logic [6:0] out_year,
  output logic       out_write_strobe
);
  import ctse_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  cmd_t       s1_cmd_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] cursor_r;
  logic [2:0] cursor_nxt;
  time_t      time_r;
  time_t      time_nxt;
  logic       strobe_r;
  logic       strobe_nxt;
  logic       in_xfer;
  logic       out_xfer;
  logic       s1_go;

  // Handshake: stage 1 moves on when the result slot is free or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_xfer ? 1'b0 : out_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_xfer) begin
      s1_cmd_r.kind <= kind_t'(in_kind);
      s1_cmd_r.step <= $signed(in_step);
      s1_cmd_r.load <= '{second:  in_load_second,
                         minute:  in_load_minute,
                         hour:    in_load_hour,
                         weekday: in_load_weekday,
                         day:     in_load_day,
                         month:   in_load_month,
                         year:    in_load_year};
    end
  end

  // Next-state pass
  ctse_next u_next (
    .cmd        (s1_cmd_r),
    .cursor     (cursor_r),
    .cur_time   (time_r),
    .cursor_nxt (cursor_nxt),
    .time_nxt   (time_nxt),
    .strobe     (strobe_nxt)
  );

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cursor_r    <= CUR_NONE;
      time_r      <= '{second: 6'd0, minute: 6'd0, hour: 5'd0, weekday: 3'd1,
                       day: 5'd1, month: 4'd1, year: 7'd0};
      strobe_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        cursor_r <= cursor_nxt;
        time_r   <= time_nxt;
        strobe_r <= strobe_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_editing      = (cursor_r != CUR_NONE);
  assign out_cursor       = cursor_r;
  assign out_second       = time_r.second;
  assign out_minute       = time_r.minute;
  assign out_hour         = time_r.hour;
  assign out_weekday      = time_r.weekday;
  assign out_day          = time_r.day;
  assign out_month        = time_r.month;
  assign out_year         = time_r.year;
  assign out_write_strobe = strobe_r;

  // Checks
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted command did not reach the input register");

  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("command in input register was not turned into a result");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go && !in_xfer) |=> (s1_valid_r && $stable(s1_cmd_r)))
    else $error("waiting command changed or vanished");

  a_date_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && strobe_r) |-> (time_r.day <= month_days(time_r.month, time_r.year)))
    else $error("date exceeds month length after a change");

endmodule

`default_nettype wire
